// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nnis_pkg.sv =====
// Shared constants, codes and controller interface types of the image scaler.
package nnis_pkg;

	// Frame store geometry; the source side limit equals one unit of scale.
	localparam int MAX_SIDE   = 256;
	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int SRC_W      = $clog2(MAX_SIDE);
	localparam int SIDE_W     = SRC_W + 1;
	localparam int FRAC_W     = 8;
	localparam int SCALE_W    = 16;
	localparam int COORD_W    = 16;
	localparam int PIX_W      = 8;
	localparam int STEP_W     = $clog2(FRAC_W);
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_DATA_W = PIX_W + 2 * COORD_W;

	// Operation carried on the input tuser.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_SCALE      = 2'd2
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_wr;
		logic size;
		logic fix_pos;
		logic div_start;
		logic div_sel_x;
		logic cap;
		logic addr;
		logic read;
		logic emit;
		logic empty;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== src/nnis_div.sv =====
// Iterative restoring divider for (coord << 8) / scale with a clamp on the quotient.
module nnis_div import nnis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] num,
	input  logic [SCALE_W-1:0] den,
	input  logic [SRC_W-1:0]   lim,
	output logic               done,
	output logic [SRC_W-1:0]   quot
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [SCALE_W-1:0] rem_q;
	logic [FRAC_W-1:0]  q_q;
	logic [SCALE_W:0]   rem2;
	logic [SCALE_W:0]   diff;
	logic               ge;

	// One quotient bit per cycle: shift in a zero from the fraction, try a subtract.
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den};
	assign ge   = (rem2 >= {1'b0, den});

	// Sequencing. A coordinate at or above the divisor gives a quotient of at least
	// 256, which always clamps, so it finishes at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (num >= den) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			q_q   <= (num >= den) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SCALE_W-1:0] : rem2[SCALE_W-1:0];
			q_q   <= {q_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = (q_q > lim) ? lim : q_q;

endmodule

// ===== src/nnis_dp.sv =====
// Datapath: configuration, frame store, pointers, size and address arithmetic, output register.
module nnis_dp import nnis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SCALE_W-1:0]    cfg_data,
	input  logic [PIX_W-1:0]      pixel_in,
	input  ctrl_cmd_t             cmd,
	output ctrl_sts_t             sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	logic [SIDE_W-1:0]    src_width_q;
	logic [SIDE_W-1:0]    src_height_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [ADDR_W-1:0]    load_ptr_q;
	logic [COORD_W-1:0]   row_q;
	logic [COORD_W-1:0]   col_q;
	logic [COORD_W-1:0]   ow_q;
	logic [COORD_W-1:0]   oh_q;
	logic [SRC_W-1:0]     sy_q;
	logic [SRC_W-1:0]     sx_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [PIX_W-1:0]     rd_data_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                 m_tlast_q;
	logic [PIX_W-1:0]     mem [MAX_PIXELS];

	logic [SIDE_W-1:0]    w_eff;
	logic [SIDE_W-1:0]    h_eff;
	logic [2*SIDE_W-1:0]  frame;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W:0]      wr_next;
	logic [SIDE_W+SCALE_W-1:0] prod_w;
	logic [SIDE_W+SCALE_W-1:0] prod_h;
	logic [SIDE_W-1:0]    w_m1;
	logic [SIDE_W-1:0]    h_m1;
	logic [COORD_W-1:0]   div_num;
	logic [SRC_W-1:0]     div_lim;
	logic                 div_done;
	logic [SRC_W-1:0]     div_quot;
	logic [SRC_W+SIDE_W:0] idx;
	logic                 last;
	logic [COORD_W:0]     col_inc;

	// Source sides saturate at the store's side limit.
	assign w_eff = (src_width_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_width_q;
	assign h_eff = (src_height_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_height_q;
	assign w_m1  = w_eff - 1'b1;
	assign h_m1  = h_eff - 1'b1;

	// Load address with wrap at the frame size.
	assign frame   = w_eff * h_eff;
	assign wr_addr = ({{(2*SIDE_W-ADDR_W){1'b0}}, load_ptr_q} >= frame) ? '0 : load_ptr_q;
	assign wr_next = {1'b0, wr_addr} + 1'b1;

	// Scaled sizes; the product never exceeds 24 bits, so the size needs no saturation.
	assign prod_w = w_eff * scale_q;
	assign prod_h = h_eff * scale_q;

	// Shared divider, fed with the row or the column.
	assign div_num = cmd.div_sel_x ? col_q : row_q;
	assign div_lim = cmd.div_sel_x ? w_m1[SRC_W-1:0] : h_m1[SRC_W-1:0];

	nnis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (scale_q),
		.lim    (div_lim),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Store index of the selected source pixel.
	assign idx = sy_q * w_eff + {{(SIDE_W+1){1'b0}}, sx_q};

	// Position stepping.
	assign last    = (row_q == oh_q - 1'b1) && (col_q == ow_q - 1'b1);
	assign col_inc = {1'b0, col_q} + 1'b1;

	// Configuration and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SIDE_W'(MAX_SIDE);
			src_height_q <= SIDE_W'(MAX_SIDE);
			scale_q      <= SCALE_W'(1 << FRAC_W);
			load_ptr_q   <= '0;
			row_q        <= '0;
			col_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SRC_WIDTH:  src_width_q  <= cfg_data[SIDE_W-1:0];
					CFG_SRC_HEIGHT: src_height_q <= cfg_data[SIDE_W-1:0];
					CFG_SCALE:      scale_q      <= cfg_data;
					default:        ;
				endcase
			end
			if (cmd.load_wr && frame != '0) begin
				load_ptr_q <= ({{(2*SIDE_W-ADDR_W-1){1'b0}}, wr_next} >= frame) ?
					'0 : wr_next[ADDR_W-1:0];
			end
			if (cmd.fix_pos && (row_q >= oh_q || col_q >= ow_q)) begin
				row_q <= '0;
				col_q <= '0;
			end
			if (cmd.emit) begin
				if (cmd.empty || last) begin
					load_ptr_q <= '0;
					row_q      <= '0;
					col_q      <= '0;
				end else if (col_inc >= {1'b0, ow_q}) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc[COORD_W-1:0];
				end
			end
		end
	end

	// Frame store: one write port for loads, one registered read port for emits.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && frame != '0) begin
			mem[wr_addr] <= pixel_in;
		end
		if (cmd.read) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// Working registers of one emit.
	always_ff @(posedge clk) begin
		if (cmd.size) begin
			ow_q <= prod_w[FRAC_W +: COORD_W];
			oh_q <= prod_h[FRAC_W +: COORD_W];
		end
		if (cmd.cap && div_done) begin
			if (cmd.div_sel_x) begin
				sx_q <= div_quot;
			end else begin
				sy_q <= div_quot;
			end
		end
		if (cmd.addr) begin
			addr_q <= idx[ADDR_W-1:0];
		end
	end

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.empty) begin
				m_tdata_q <= '0;
				m_tlast_q <= 1'b1;
			end else begin
				m_tdata_q <= {col_q, row_q, rd_data_q};
				m_tlast_q <= last;
			end
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign m_tlast      = m_tlast_q;
	assign sts.empty    = (ow_q == '0) || (oh_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

// ===== src/nnis_ctrl.sv =====
// Controller: sequences loads and the steps of each emit over the datapath.
module nnis_ctrl import nnis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_op,
	output logic      s_tready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SIZE,
		S_CHECK,
		S_DIVY,
		S_WAITY,
		S_DIVX,
		S_WAITX,
		S_ADDR,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q;
	logic   empty_q;

	// State register and the empty-output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			empty_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && op_t'(s_op) == OP_EMIT) begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE:  state_q <= S_CHECK;
				S_CHECK: begin
					empty_q <= sts.empty;
					state_q <= sts.empty ? S_DONE : S_DIVY;
				end
				S_DIVY:  state_q <= S_WAITY;
				S_WAITY: begin
					if (sts.div_done) begin
						state_q <= S_DIVX;
					end
				end
				S_DIVX:  state_q <= S_WAITX;
				S_WAITX: begin
					if (sts.div_done) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR:  state_q <= S_READ;
				S_READ:  state_q <= S_DONE;
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd           = '0;
		cmd.empty     = empty_q;
		cmd.load_wr   = (state_q == S_IDLE) && s_tvalid && op_t'(s_op) == OP_LOAD;
		cmd.size      = (state_q == S_SIZE);
		cmd.fix_pos   = (state_q == S_CHECK) && !sts.empty;
		cmd.div_start = (state_q == S_DIVY) || (state_q == S_DIVX);
		cmd.div_sel_x = (state_q == S_DIVX) || (state_q == S_WAITX);
		cmd.cap       = (state_q == S_WAITY) || (state_q == S_WAITX);
		cmd.addr      = (state_q == S_ADDR);
		cmd.read      = (state_q == S_READ);
		cmd.emit      = (state_q == S_DONE) && sts.out_free;
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

// ===== src/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor image scaler for 8-bit pixels. A load request (tuser 0) writes the next
// source pixel into a 64K-byte frame store in raster order, and the input stays ready. An
// emit request (tuser 1) returns the next pixel of the scaled image with its row, column
// and a last flag: it sizes the image, checks for an empty output, turns the row and then
// the column into source coordinates on the shared eight-step divider, reads the store and
// loads the result into the output register once it is free. A coordinate at or above the
// scale skips its division steps; an empty output skips the divisions, address and read.
// The next request is taken in the cycle after the result is loaded, while that result
// may still wait for the sink. Sizes are min(side, 256) * scale_q8 >> 8 per axis; an empty
// output answers with pixel 0, row 0, column 0 and last set. The last pixel, or an empty
// answer, returns the load and emit pointers to zero. Configuration is taken at any time,
// but is only meant to change while no request is in flight.
module nearest_neighbor_image_scaler import nnis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic                  s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] pixel_out, [23:8] out_row, [39:24] out_col
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SCALE_W-1:0]    cfg_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	nnis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nnis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/nnis_checker.sv =====
// Port-level checker for the image scaler and its bind to the top level.
`include "assert_macros.svh"

module nnis_checker import nnis_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// A stalled result holds its payload.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// An accepted emit request closes the input until its result is produced.
	`ASSERT_NEXT(a_emit_blocks, s_tvalid && s_tready && s_tuser == OP_EMIT, !s_tready, "input open during emit")

	// A load request finishes in its own cycle.
	`ASSERT_NEXT(a_load_single, s_tvalid && s_tready && s_tuser == OP_LOAD, s_tready, "load request stalled the input")

	// A new result only appears from the end of an emit, never from the idle state.
	`ASSERT_IMP(a_result_origin, $rose(m_tvalid), !$past(s_tready), "result appeared without an emit")

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the nearest-neighbor image scaler with a built-in pixel predictor.
module tb;
	import nnis_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int SETTLE       = 40;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int EMIT_CAP     = 60;

	// One pixel of the scaled image as the block reports it.
	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} scaled_pixel_t;

	// One request to the block, with the pixel it must produce if it is an emit.
	typedef struct {
		op_t              op;
		logic [PIX_W-1:0] pixel;
		int               gap;
		bit               has_result;
		scaled_pixel_t    res;
	} scaler_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata = '0;
	logic                  s_tuser = OP_LOAD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_WIDTH;
	logic [SCALE_W-1:0]    cfg_data = '0;

	nearest_neighbor_image_scaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state: registers, frame store with a written mark, and the raster pointers.
	bit [SIDE_W-1:0]   reg_width = 9'd256;
	bit [SIDE_W-1:0]   reg_height = 9'd256;
	bit [SCALE_W-1:0]  reg_scale = 16'd256;
	logic [PIX_W-1:0]  frame [MAX_PIXELS];
	bit                written [MAX_PIXELS];
	int unsigned       load_pos = 0;
	int unsigned       emit_r = 0;
	int unsigned       emit_c = 0;

	scaler_req_t   requests[$];
	scaled_pixel_t pixels_due[$];
	scaler_req_t   offered;
	scaled_pixel_t wanted;
	int            requests_queued = 0;
	int            requests_taken = 0;
	int            gap_count = 0;
	int            idle_max = 18;
	int            results_seen = 0;
	int            stall_left = 0;
	int            hold_left = 0;
	int            sink_wait = 0;
	int            failures = 0;
	int            cycles = 0;

	function automatic int unsigned clamp_side(bit [SIDE_W-1:0] v);
		return (v > MAX_SIDE) ? MAX_SIDE : v;
	endfunction

	// Scaled size of one axis; the product is saturated at the coordinate range.
	function automatic int unsigned scaled(int unsigned side);
		longint unsigned s;
		s = side;
		s = (s * reg_scale) >> FRAC_W;
		if (s > 65535)
			s = 65535;
		return 32'(s);
	endfunction

	function automatic void clear_positions();
		load_pos = 0;
		emit_r = 0;
		emit_c = 0;
	endfunction

	// Where the next emit lands. Returns 1 for an empty output image.
	function automatic bit emit_target(output int unsigned r, c, idx, ow, oh);
		int unsigned w, h, sy, sx;
		w = clamp_side(reg_width);
		h = clamp_side(reg_height);
		ow = scaled(w);
		oh = scaled(h);
		r = 0;
		c = 0;
		idx = 0;
		if (ow == 0 || oh == 0 || reg_scale == 0)
			return 1'b1;
		r = emit_r;
		c = emit_c;
		// A position left outside the image by a register change restarts the raster.
		if (r >= oh || c >= ow) begin
			r = 0;
			c = 0;
		end
		sy = (r << FRAC_W) / reg_scale;
		sx = (c << FRAC_W) / reg_scale;
		if (sy >= h)
			sy = h - 1;
		if (sx >= w)
			sx = w - 1;
		idx = sy * w + sx;
		return 1'b0;
	endfunction

	function automatic bit emit_readable();
		int unsigned r, c, idx, ow, oh;
		if (emit_target(r, c, idx, ow, oh))
			return 1'b1;
		return idx < MAX_PIXELS && written[ADDR_W'(idx)];
	endfunction

	function automatic void predict_emit(output scaled_pixel_t res);
		int unsigned r, c, idx, ow, oh;
		res = '0;
		if (emit_target(r, c, idx, ow, oh)) begin
			res.last = 1'b1;
			clear_positions();
			return;
		end
		if (idx < MAX_PIXELS)
			res.pixel = frame[ADDR_W'(idx)];
		res.row = COORD_W'(r);
		res.col = COORD_W'(c);
		res.last = (r == oh - 1) && (c == ow - 1);
		if (res.last) begin
			clear_positions();
		end else begin
			c++;
			if (c >= ow) begin
				c = 0;
				r++;
			end
			emit_r = r;
			emit_c = c;
		end
	endfunction

	// Loads wrap at the end of the frame and are dropped while the frame is empty.
	function automatic void store_pixel(logic [PIX_W-1:0] pix);
		int unsigned fsize;
		fsize = clamp_side(reg_width) * clamp_side(reg_height);
		if (fsize == 0)
			return;
		if (load_pos >= fsize)
			load_pos = 0;
		frame[ADDR_W'(load_pos)] = pix;
		written[ADDR_W'(load_pos)] = 1'b1;
		load_pos++;
		if (load_pos >= fsize)
			load_pos = 0;
	endfunction

	function automatic void queue_request(op_t op, logic [PIX_W-1:0] pix);
		scaler_req_t q;
		q.op = op;
		q.pixel = pix;
		q.gap = $urandom_range(idle_max, 0);
		q.has_result = 1'b0;
		q.res = '0;
		if (op == OP_LOAD) begin
			store_pixel(pix);
		end else begin
			predict_emit(q.res);
			q.has_result = 1'b1;
		end
		requests.push_back(q);
		requests_queued++;
	endfunction

	// An emit that would read a never-written store entry becomes a load instead.
	function automatic void queue_emit_or_load(op_t op);
		if (op == OP_EMIT && !emit_readable())
			op = OP_LOAD;
		queue_request(op, PIX_W'($urandom));
	endfunction

	function automatic void check_field(string name, logic [COORD_W-1:0] want,
			logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic bit [SIDE_W-1:0] pick_side();
		case ($urandom_range(19, 0))
			0: return SIDE_W'(0);
			1: return SIDE_W'(1);
			2: return SIDE_W'(MAX_SIDE);
			3: return SIDE_W'($urandom_range(511, MAX_SIDE + 1));
			default: return SIDE_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic bit [SCALE_W-1:0] pick_scale();
		case ($urandom_range(29, 0))
			0: return SCALE_W'(0);
			1: return SCALE_W'(1);
			2: return 16'hFFFF;
			3, 4: return SCALE_W'($urandom);
			default: return SCALE_W'($urandom_range(1024, 32));
		endcase
	endfunction

	// Wait until every request is taken and every pixel returned, then let the block settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (requests_taken != requests_queued || pixels_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [SCALE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SRC_WIDTH: reg_width = val[SIDE_W-1:0];
			CFG_SRC_HEIGHT: reg_height = val[SIDE_W-1:0];
			default: reg_scale = val;
		endcase
	endtask

	task automatic configure(bit [SIDE_W-1:0] w, bit [SIDE_W-1:0] h, bit [SCALE_W-1:0] sc);
		wait_idle();
		write_reg(CFG_SRC_WIDTH, SCALE_W'(w));
		write_reg(CFG_SRC_HEIGHT, SCALE_W'(h));
		write_reg(CFG_SCALE, sc);
	endtask

	// Request driver: presents queued requests after each one's drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_LOAD;
			gap_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (offered.has_result)
					pixels_due.push_back(offered.res);
				requests_taken <= requests_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (requests.size() > 0 && gap_count >= requests[0].gap) begin
					offered = requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= offered.pixel;
					s_tuser <= offered.op;
					gap_count <= 0;
				end else begin
					s_tvalid <= 1'b0;
					if (requests.size() > 0)
						gap_count <= gap_count + 1;
				end
			end
		end
	end

	// Pixel monitor: checks each returned pixel and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else if (m_tvalid && m_tready) begin
			if (pixels_due.size() == 0) begin
				$error("unexpected pixel: data %h, last %b", m_tdata, m_tlast);
				failures++;
			end else begin
				wanted = pixels_due.pop_front();
				check_field("pixel_out", COORD_W'(wanted.pixel), COORD_W'(m_tdata[PIX_W-1:0]));
				check_field("out_row", wanted.row, m_tdata[PIX_W+COORD_W-1:PIX_W]);
				check_field("out_col", wanted.col, m_tdata[OUT_DATA_W-1:PIX_W+COORD_W]);
				check_field("last", COORD_W'(wanted.last), COORD_W'(m_tlast));
			end
			results_seen = results_seen + 1;
			// One long hold-off lets the block back up into its input.
			if (results_seen == HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				sink_wait = $urandom_range(idle_max, 0);
				stall_left <= sink_wait;
				m_tready <= (sink_wait == 0);
			end
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: directed corner cases, then random phases, each under its own setting.
	initial begin
		bit [SIDE_W-1:0]  w, h;
		bit [SCALE_W-1:0] sc;
		longint unsigned  outs;
		int               n, goal;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// A 2x2 frame at unit scale, with one load past the end that wraps to the start.
		configure(9'd2, 9'd2, 16'd256);
		queue_request(OP_LOAD, 8'h00);
		queue_request(OP_LOAD, 8'hFF);
		queue_request(OP_LOAD, 8'hA5);
		queue_request(OP_LOAD, 8'h5A);
		queue_request(OP_LOAD, 8'h3C);
		repeat (4) queue_request(OP_EMIT, 8'hFF);

		// Zero width: the load is dropped and the emit answers an empty image.
		configure(9'd0, 9'd2, 16'd256);
		queue_request(OP_LOAD, 8'h81);
		queue_request(OP_EMIT, 8'h00);

		// Zero scale, and a scale too small to give a single pixel.
		configure(9'd2, 9'd2, 16'd0);
		queue_request(OP_EMIT, 8'h00);
		configure(9'd2, 9'd2, 16'd1);
		queue_request(OP_EMIT, 8'h00);

		// Largest scale, then a shrink that leaves the position outside the image.
		configure(9'd1, 9'd1, 16'hFFFF);
		repeat (3) queue_request(OP_EMIT, 8'h00);
		configure(9'd2, 9'd2, 16'd128);
		queue_request(OP_EMIT, 8'h00);

		// Width register above the side limit saturates.
		configure(9'd511, 9'd1, 16'd256);
		queue_request(OP_LOAD, 8'h7E);
		queue_request(OP_LOAD, 8'h01);
		queue_request(OP_LOAD, 8'hC3);
		repeat (2) queue_request(OP_EMIT, 8'h00);

		goal = requests_queued + RANDOM_ITEMS;
		while (requests_queued < goal) begin
			w = pick_side();
			h = pick_side();
			sc = pick_scale();
			// Keep frames small enough to be filled by loads in one phase.
			if (clamp_side(w) * clamp_side(h) > 512) begin
				if ($urandom_range(1, 0))
					h = 1;
				else
					w = 1;
			end
			idle_max = ($urandom_range(3, 0) == 0) ? 0 : 18;
			configure(w, h, sc);
			if ($urandom_range(3, 0) != 0) begin
				// Well-formed: fill the frame, then read the scaled image out.
				n = clamp_side(w) * clamp_side(h);
				repeat (n) queue_request(OP_LOAD, PIX_W'($urandom));
				outs = longint'(scaled(clamp_side(w))) * scaled(clamp_side(h));
				n = (outs == 0) ? 2 : ((outs > EMIT_CAP) ? EMIT_CAP : int'(outs));
				repeat (n) queue_emit_or_load(OP_EMIT);
			end else begin
				n = $urandom_range(60, 10);
				repeat (n) queue_emit_or_load(op_t'($urandom_range(1, 0)));
			end
		end

		wait_idle();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/nnis_pkg.sv
src/nnis_div.sv
src/nnis_dp.sv
src/nnis_ctrl.sv
src/nearest_neighbor_image_scaler.sv
src/nnis_checker.sv
tb/tb.sv
